// ===== src/artdmx_serial_stream_parser_assert.svh =====
// Assertion macros for the ArtDmx stream parser.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ARTDMX_SERIAL_STREAM_PARSER_ASSERT_SVH
`define ARTDMX_SERIAL_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ARTDMX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARTDMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ARTDMX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define ARTDMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/artdmx_pkg.sv =====
// Shared types and constants of the ArtDmx stream parser.
// No dependencies.
package artdmx_pkg;

  localparam int MAX_CHANNELS = 512;
  localparam int MIN_CHANNELS = 2;
  localparam int HDR_LEN      = 8;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_OPCODE = 2'd1,
    KIND_LENGTH = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] universe_id;
    logic [7:0]  sequence_value;
    logic [9:0]  channel_count;
    logic [8:0]  channel_index;
    logic [7:0]  channel_value;
    logic        frame_last;
    logic        stream_synced;
  } res_t;

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h41;
      3'd1: b = 8'h72;
      3'd2: b = 8'h74;
      3'd3: b = 8'h2D;
      3'd4: b = 8'h4E;
      3'd5: b = 8'h65;
      3'd6: b = 8'h74;
      3'd7: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/artdmx_parse_core.sv =====
// Per-byte ArtDmx parse state and result formation.
// Depends on artdmx_pkg and artdmx_serial_stream_parser_assert.svh.
`include "artdmx_serial_stream_parser_assert.svh"

module artdmx_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  output logic              res_vld,
  output artdmx_pkg::res_t  res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_OPCODE,
    PH_FIELDS,
    PH_DATA
  } phase_t;

  localparam logic [9:0] OFS_OP_LO   = 10'd8;
  localparam logic [9:0] OFS_OP_HI   = 10'd9;
  localparam logic [9:0] OFS_FIELDS  = 10'd10;
  localparam logic [9:0] OFS_SEQ     = 10'd12;
  localparam logic [9:0] OFS_SUBUNI  = 10'd14;
  localparam logic [9:0] OFS_NET     = 10'd15;
  localparam logic [9:0] OFS_LEN_HI  = 10'd16;
  localparam logic [9:0] OFS_LEN_LO  = 10'd17;
  localparam logic [7:0] OP_LOW      = 8'h00;
  localparam logic [7:0] OP_HIGH     = 8'h50;

  phase_t      phase_r,  phase_nxt;
  logic [9:0]  pos_r,    pos_nxt;
  logic [7:0]  op_lo_r,  op_lo_nxt;
  logic [7:0]  seq_r,    seq_nxt;
  logic [15:0] univ_r,   univ_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [9:0]  len_r,    len_nxt;
  logic        sync_r,   sync_nxt;

  logic [15:0] len_full;
  logic        len_bad;
  logic [10:0] pos_inc;
  logic        last;

  assign len_full = {len_hi_r, rx_byte};
  assign len_bad  = (len_full < 16'(artdmx_pkg::MIN_CHANNELS)) ||
                    (len_full > 16'(artdmx_pkg::MAX_CHANNELS));
  assign pos_inc  = {1'b0, pos_r} + 11'd1;
  assign last     = pos_inc >= {1'b0, len_r};

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    op_lo_nxt  = op_lo_r;
    seq_nxt    = seq_r;
    univ_nxt   = univ_r;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    sync_nxt   = sync_r;
    res_vld    = 1'b0;
    res        = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r < 10'(artdmx_pkg::HDR_LEN) &&
            rx_byte == artdmx_pkg::hdr_byte(pos_r[2:0])) begin
          pos_nxt = pos_inc[9:0];
          if (pos_inc[9:0] == 10'(artdmx_pkg::HDR_LEN)) begin
            sync_nxt  = 1'b1;
            phase_nxt = PH_OPCODE;
          end
        end else begin
          // mismatching byte is dropped, not retried as a header start
          sync_nxt  = 1'b0;
          pos_nxt   = '0;
          phase_nxt = PH_HEADER;
        end
      end

      PH_OPCODE: begin
        if (pos_r == OFS_OP_LO) begin
          op_lo_nxt = rx_byte;
          pos_nxt   = OFS_OP_HI;
        end else if (op_lo_r == OP_LOW && rx_byte == OP_HIGH) begin
          phase_nxt = PH_FIELDS;
          pos_nxt   = OFS_FIELDS;
        end else begin
          sync_nxt        = 1'b0;
          pos_nxt         = '0;
          phase_nxt       = PH_HEADER;
          res_vld         = 1'b1;
          res.result_kind = artdmx_pkg::KIND_OPCODE;
        end
      end

      PH_FIELDS: begin
        pos_nxt = pos_inc[9:0];
        if (pos_r >= OFS_LEN_LO) begin
          len_nxt = len_full[9:0];
          if (len_bad) begin
            sync_nxt        = 1'b0;
            pos_nxt         = '0;
            phase_nxt       = PH_HEADER;
            res_vld         = 1'b1;
            res.result_kind = artdmx_pkg::KIND_LENGTH;
          end else begin
            phase_nxt = PH_DATA;
            pos_nxt   = '0;
          end
        end else if (pos_r == OFS_SEQ) begin
          seq_nxt = rx_byte;
        end else if (pos_r == OFS_SUBUNI) begin
          univ_nxt[7:0] = rx_byte;
        end else if (pos_r == OFS_NET) begin
          univ_nxt[15:8] = rx_byte;
        end else if (pos_r == OFS_LEN_HI) begin
          len_hi_nxt = rx_byte;
        end
      end

      PH_DATA: begin
        res_vld            = 1'b1;
        res.result_kind    = artdmx_pkg::KIND_DATA;
        res.universe_id    = univ_r;
        res.sequence_value = seq_r;
        res.channel_count  = len_r;
        res.channel_index  = pos_r[8:0];
        res.channel_value  = rx_byte;
        res.frame_last     = last;
        res.stream_synced  = sync_r;
        if (last) begin
          pos_nxt   = '0;
          phase_nxt = PH_HEADER;
        end else begin
          pos_nxt = pos_inc[9:0];
        end
      end

      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    if (!step_en) begin
      res_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      op_lo_r  <= '0;
      seq_r    <= '0;
      univ_r   <= '0;
      len_hi_r <= '0;
      len_r    <= '0;
      sync_r   <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      op_lo_r  <= op_lo_nxt;
      seq_r    <= seq_nxt;
      univ_r   <= univ_nxt;
      len_hi_r <= len_hi_nxt;
      len_r    <= len_nxt;
      sync_r   <= sync_nxt;
    end
  end

  `ARTDMX_ASSERT_NOW(a_hdr_pos, clk, rst_n, phase_r == PH_HEADER, pos_r < 10'(artdmx_pkg::HDR_LEN), "header offset out of range")
  `ARTDMX_ASSERT_NOW(a_data_sync, clk, rst_n, phase_r != PH_HEADER, sync_r, "parsing past header without sync")
  `ARTDMX_ASSERT_NOW(a_data_pos, clk, rst_n, phase_r == PH_DATA, pos_r < len_r, "data index beyond frame length")
  `ARTDMX_ASSERT_NXT(a_err_restart, clk, rst_n, res_vld && res.result_kind != artdmx_pkg::KIND_DATA, phase_r == PH_HEADER && !sync_r, "error did not restart search")

endmodule

// ===== src/artdmx_serial_stream_parser.sv =====
// Top level of the ArtDmx stream parser: input register, parse core, result register.
// Depends on artdmx_pkg and artdmx_parse_core.

// Accepts one serial byte per clock and returns, through the input register and
// the result register, either nothing (header, opcode and field bytes), a tagged
// channel data byte, or an error transaction for a bad opcode or data length.
// Throughput is one byte per clock while no finished result waits on out_ready,
// set by the state update in the parse core; the input register can still take
// one byte while a result waits, and back pressure beyond that stalls in_ready.
module artdmx_serial_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_universe_id,
  output logic [7:0]  out_sequence_value,
  output logic [9:0]  out_channel_count,
  output logic [8:0]  out_channel_index,
  output logic [7:0]  out_channel_value,
  output logic        out_frame_last,
  output logic        out_stream_synced
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             out_vld_r;
  artdmx_pkg::res_t out_res_r;

  logic             advance;
  logic             res_vld;
  artdmx_pkg::res_t res;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  artdmx_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (res_vld) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_result_kind    = out_res_r.result_kind;
  assign out_universe_id    = out_res_r.universe_id;
  assign out_sequence_value = out_res_r.sequence_value;
  assign out_channel_count  = out_res_r.channel_count;
  assign out_channel_index  = out_res_r.channel_index;
  assign out_channel_value  = out_res_r.channel_value;
  assign out_frame_last     = out_res_r.frame_last;
  assign out_stream_synced  = out_res_r.stream_synced;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for artdmx_serial_stream_parser: serial byte stream in,
// tagged channel data and error transactions out, checked against an inline parser model.
// Depends on artdmx_pkg and the parser RTL.
module tb_top;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          ITEM_TARGET    = 500;
  localparam logic [7:0]  DMX_OP_LO      = 8'h00;
  localparam logic [7:0]  DMX_OP_HI      = 8'h50;
  localparam logic [7:0]  ARTNET_ID [artdmx_pkg::HDR_LEN] =
    '{8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00};

  typedef enum logic [1:0] {
    SEEK_HDR,
    GET_OPCODE,
    GET_FIELDS,
    STREAM_DATA
  } parse_state_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  out_result_kind;
  logic [15:0] out_universe_id;
  logic [7:0]  out_sequence_value;
  logic [9:0]  out_channel_count;
  logic [8:0]  out_channel_index;
  logic [7:0]  out_channel_value;
  logic        out_frame_last;
  logic        out_stream_synced;

  artdmx_serial_stream_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_universe_id    (out_universe_id),
    .out_sequence_value (out_sequence_value),
    .out_channel_count  (out_channel_count),
    .out_channel_index  (out_channel_index),
    .out_channel_value  (out_channel_value),
    .out_frame_last     (out_frame_last),
    .out_stream_synced  (out_stream_synced)
  );

  logic [7:0]        rx_bytes_q[$];
  artdmx_pkg::res_t  dmx_expect_q[$];
  artdmx_pkg::res_t  exp_r;
  int                err_cnt     = 0;
  int                idle_cycles = 0;
  int                send_gap    = 0;
  int                recv_stall  = 0;
  bit                quiet       = 1'b0;
  logic              in_fire     = 1'b0;

  // parser model state
  parse_state_t trk_state  = SEEK_HDR;
  logic [9:0]   trk_pos    = '0;
  logic [7:0]   trk_op_lo  = '0;
  logic [7:0]   trk_seq    = '0;
  logic [15:0]  trk_univ   = '0;
  logic [15:0]  trk_len    = '0;
  logic         trk_synced = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic parser_resync(input bit keep_sync);
    if (!keep_sync) trk_synced = 1'b0;
    trk_pos   = '0;
    trk_state = SEEK_HDR;
  endtask

  // Advance the parser model by one byte; queue the transaction it produces, if any.
  task automatic track_artdmx_byte(input logic [7:0] b);
    artdmx_pkg::res_t r;
    bit               frame_end;
    r = '0;
    case (trk_state)
      SEEK_HDR: begin
        // a mismatching byte is dropped, not retried as a header start
        if (b == ARTNET_ID[trk_pos[2:0]]) begin
          trk_pos = trk_pos + 10'd1;
          if (trk_pos == 10'(artdmx_pkg::HDR_LEN)) begin
            trk_synced = 1'b1;
            trk_state  = GET_OPCODE;
          end
        end else begin
          parser_resync(1'b0);
        end
      end
      GET_OPCODE: begin
        if (trk_pos == 10'(artdmx_pkg::HDR_LEN)) begin
          trk_op_lo = b;
          trk_pos   = 10'(artdmx_pkg::HDR_LEN + 1);
        end else if (trk_op_lo == DMX_OP_LO && b == DMX_OP_HI) begin
          trk_state = GET_FIELDS;
          trk_pos   = 10'(artdmx_pkg::HDR_LEN + 2);
        end else begin
          parser_resync(1'b0);
          r.result_kind = artdmx_pkg::KIND_OPCODE;
          dmx_expect_q.push_back(r);
        end
      end
      GET_FIELDS: begin
        case (trk_pos)
          10'd12: trk_seq = b;
          10'd14: trk_univ[7:0] = b;
          10'd15: trk_univ[15:8] = b;
          10'd16: trk_len[15:8] = b;
          default: ;
        endcase
        if (trk_pos >= 10'd17) begin
          trk_len[7:0] = b;
          if (trk_len < 16'(artdmx_pkg::MIN_CHANNELS) ||
              trk_len > 16'(artdmx_pkg::MAX_CHANNELS)) begin
            parser_resync(1'b0);
            r.result_kind = artdmx_pkg::KIND_LENGTH;
            dmx_expect_q.push_back(r);
          end else begin
            trk_state = STREAM_DATA;
            trk_pos   = '0;
          end
        end else begin
          trk_pos = trk_pos + 10'd1;
        end
      end
      STREAM_DATA: begin
        frame_end        = (int'(trk_pos) + 1 >= int'(trk_len));
        r.result_kind    = artdmx_pkg::KIND_DATA;
        r.universe_id    = trk_univ;
        r.sequence_value = trk_seq;
        r.channel_count  = trk_len[9:0];
        r.channel_index  = trk_pos[8:0];
        r.channel_value  = b;
        r.frame_last     = frame_end;
        r.stream_synced  = trk_synced;
        dmx_expect_q.push_back(r);
        if (frame_end) parser_resync(1'b1);
        else trk_pos = trk_pos + 10'd1;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Queue one ArtDmx packet; ndata channel bytes follow the length field.
  task automatic push_packet(input logic [7:0] op_lo, input logic [7:0] op_hi,
                             input logic [7:0] seq, input logic [15:0] univ,
                             input logic [15:0] len, input int ndata);
    for (int i = 0; i < artdmx_pkg::HDR_LEN; i++) rx_bytes_q.push_back(ARTNET_ID[i]);
    rx_bytes_q.push_back(op_lo);
    rx_bytes_q.push_back(op_hi);
    rx_bytes_q.push_back(8'($urandom));
    rx_bytes_q.push_back(8'($urandom));
    rx_bytes_q.push_back(seq);
    rx_bytes_q.push_back(8'($urandom));
    rx_bytes_q.push_back(univ[7:0]);
    rx_bytes_q.push_back(univ[15:8]);
    rx_bytes_q.push_back(len[15:8]);
    rx_bytes_q.push_back(len[7:0]);
    for (int i = 0; i < ndata; i++) rx_bytes_q.push_back(8'($urandom));
  endtask

  task automatic push_dmx_frame(input logic [15:0] len);
    push_packet(DMX_OP_LO, DMX_OP_HI, 8'($urandom), 16'($urandom), len, int'(len));
  endtask

  // first n header bytes, then one that breaks the header
  task automatic push_broken_header(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) rx_bytes_q.push_back(ARTNET_ID[i]);
    b = 8'($urandom);
    if (b == ARTNET_ID[n]) b = ~b;
    rx_bytes_q.push_back(b);
  endtask

  // stimulus
  initial begin
    logic [7:0]  op_lo, op_hi;
    logic [15:0] bad_len;
    int          sel;

    // directed: header restart, extremes, opcode and length errors
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(ARTNET_ID[0]);
    push_packet(DMX_OP_LO, DMX_OP_HI, 8'h00, 16'h0000, 16'd2, 2);
    push_packet(DMX_OP_LO, DMX_OP_HI, 8'hFF, 16'hFFFF, 16'd3, 3);
    push_packet(8'h00, 8'h20, 8'h01, 16'h0001, 16'd2, 0);
    push_packet(DMX_OP_LO, DMX_OP_HI, 8'h22, 16'h1234, 16'd1, 0);
    push_packet(DMX_OP_LO, DMX_OP_HI, 8'h22, 16'h1234, 16'd513, 0);
    push_broken_header(7);
    // length high byte in use and channel index past 255
    push_packet(DMX_OP_LO, DMX_OP_HI, 8'h5A, 16'hA5C3, 16'd257, 257);

    // random: mostly well-formed frames, some errors and line noise
    while (rx_bytes_q.size() < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        if ($urandom_range(0, 9) == 0) push_dmx_frame(16'($urandom_range(13, 64)));
        else push_dmx_frame(16'($urandom_range(artdmx_pkg::MIN_CHANNELS, 12)));
      end else if (sel < 83) begin
        op_lo = 8'($urandom);
        op_hi = 8'($urandom);
        if (op_lo == DMX_OP_LO && op_hi == DMX_OP_HI) op_hi = ~op_hi;
        push_packet(op_lo, op_hi, 8'($urandom), 16'($urandom), 16'd2, 0);
      end else if (sel < 90) begin
        case ($urandom_range(0, 3))
          0: bad_len = 16'd0;
          1: bad_len = 16'd1;
          2: bad_len = 16'(artdmx_pkg::MAX_CHANNELS + 1);
          default: bad_len = 16'($urandom_range(artdmx_pkg::MAX_CHANNELS + 1, 16'hFFFF));
        endcase
        push_packet(DMX_OP_LO, DMX_OP_HI, 8'($urandom), 16'($urandom), bad_len, 0);
      end else if (sel < 95) begin
        push_broken_header(int'($urandom_range(0, artdmx_pkg::HDR_LEN - 1)));
      end else begin
        repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(8'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (rx_bytes_q.size() > 120) @(posedge clk);
    quiet = 1'b1;
    while (rx_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (dmx_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // driver: byte source and result sink, both change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (rx_bytes_q.size() > 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_bytes_q.pop_front();
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 12);
      end
    end
  end

  // monitor: model update on each accepted byte, then compare result transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) track_artdmx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (dmx_expect_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual kind %0h",
                   $time, out_result_kind);
          err_cnt++;
        end else begin
          exp_r = dmx_expect_q.pop_front();
          check_field("result_kind", 16'(exp_r.result_kind), 16'(out_result_kind));
          check_field("universe_id", exp_r.universe_id, out_universe_id);
          check_field("sequence_value", 16'(exp_r.sequence_value), 16'(out_sequence_value));
          check_field("channel_count", 16'(exp_r.channel_count), 16'(out_channel_count));
          check_field("channel_index", 16'(exp_r.channel_index), 16'(out_channel_index));
          check_field("channel_value", 16'(exp_r.channel_value), 16'(out_channel_value));
          check_field("frame_last", 16'(exp_r.frame_last), 16'(out_frame_last));
          check_field("stream_synced", 16'(exp_r.stream_synced), 16'(out_stream_synced));
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, dmx_expect_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
